### hdl/aavr_pkg.sv
package aavr_pkg;

    // configuration register map
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_X    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_Y    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_Z    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COS_ANGLE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIN_ANGLE = 3'd4;

    // extra bits carried by intermediate vectors over the data width
    localparam int HEADROOM = 2;

    // fraction bits of the coefficient format: Q1.(COEF_WIDTH-FRAC_GAP)
    localparam int FRAC_GAP = 2;

endpackage

### hdl/aavr_sat.sv
module aavr_sat #(
    parameter int IW = 22,
    parameter int OW = 20
) (
    input  logic signed [IW-1:0] x,
    output logic signed [OW-1:0] y,
    output logic                 sat
);

    logic fits;

    // fits when all bits from the result sign up are equal
    assign fits = (x[IW-1:OW-1] == {(IW-OW+1){1'b0}}) ||
                  (x[IW-1:OW-1] == {(IW-OW+1){1'b1}});
    assign sat  = ~fits;
    assign y    = fits ? x[OW-1:0] : {x[IW-1], {(OW-1){~x[IW-1]}}};

endmodule

### hdl/aavr_mulr.sv
module aavr_mulr #(
    parameter int AW   = 18,
    parameter int BW   = 18,
    parameter int FRAC = 16
) (
    input  logic                         clk,
    input  logic signed [AW-1:0]         a,
    input  logic signed [BW-1:0]         b,
    output logic signed [AW+BW-FRAC-1:0] y
);

    localparam int PW = AW + BW;
    localparam logic signed [PW-1:0] HALF = {{(PW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] biased;

    assign prod_next = PW'(a) * PW'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // round half up, then floor shift
    assign biased = prod_reg + HALF;
    assign y      = biased[PW-1:FRAC];

endmodule

### hdl/aavr_proj.sv
module aavr_proj #(
    parameter int DATA_WIDTH = 18,
    parameter int COEF_WIDTH = 18
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    input  logic signed [DATA_WIDTH-1:0]                vec  [3],
    input  logic signed [COEF_WIDTH-1:0]                axis [3],
    output logic                                        out_valid,
    output logic signed [DATA_WIDTH+aavr_pkg::HEADROOM-1:0] pz [3],
    output logic signed [DATA_WIDTH+aavr_pkg::HEADROOM-1:0] px [3]
);

    localparam int D    = DATA_WIDTH;
    localparam int C    = COEF_WIDTH;
    localparam int F    = C - aavr_pkg::FRAC_GAP;
    localparam int IW   = D + aavr_pkg::HEADROOM;
    localparam int P1W  = C + D - F;     // rounded a*v
    localparam int P3W  = C + IW - F;    // rounded a*d
    localparam int SUMW = P1W + 2;

    logic                valid1_reg, valid2_reg, valid3_reg, valid4_reg;
    logic signed [D-1:0] v1_reg [3];
    logic signed [D-1:0] v2_reg [3];
    logic signed [D-1:0] v3_reg [3];

    logic signed [P1W-1:0]  av   [3];
    logic signed [SUMW-1:0] dot_sum;
    logic signed [IW-1:0]   d_next;
    logic signed [IW-1:0]   d_reg;
    logic signed [P3W-1:0]  ad   [3];
    logic signed [IW-1:0]   pz_next [3];
    logic signed [IW:0]     px_diff [3];
    logic signed [IW-1:0]   px_next [3];
    logic signed [IW-1:0]   pz_reg  [3];
    logic signed [IW-1:0]   px_reg  [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            valid4_reg <= valid3_reg;
        end
    end

    // stage 2: projection length
    assign dot_sum = SUMW'(av[0]) + SUMW'(av[1]) + SUMW'(av[2]);

    aavr_sat #(.IW(SUMW), .OW(IW)) u_sat_d (
        .x   (dot_sum),
        .y   (d_next),
        .sat ()
    );

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        // stage 1: a_i * v_i
        aavr_mulr #(.AW(C), .BW(D), .FRAC(F)) u_mul_av (
            .clk (clk),
            .a   (axis[i]),
            .b   (vec[i]),
            .y   (av[i])
        );

        // stage 3: a_i * d
        aavr_mulr #(.AW(C), .BW(IW), .FRAC(F)) u_mul_ad (
            .clk (clk),
            .a   (axis[i]),
            .b   (d_reg),
            .y   (ad[i])
        );

        // stage 4: axial part and perpendicular remainder
        aavr_sat #(.IW(P3W), .OW(IW)) u_sat_pz (
            .x   (ad[i]),
            .y   (pz_next[i]),
            .sat ()
        );

        assign px_diff[i] = (IW+1)'(v3_reg[i]) - (IW+1)'(pz_next[i]);

        aavr_sat #(.IW(IW+1), .OW(IW)) u_sat_px (
            .x   (px_diff[i]),
            .y   (px_next[i]),
            .sat ()
        );

        always_ff @(posedge clk)
        begin
            v1_reg[i] <= vec[i];
            v2_reg[i] <= v1_reg[i];
            v3_reg[i] <= v2_reg[i];
            pz_reg[i] <= pz_next[i];
            px_reg[i] <= px_next[i];
        end

        assign pz[i] = pz_reg[i];
        assign px[i] = px_reg[i];
    end

    assign out_valid = valid4_reg;

endmodule

### hdl/aavr_turn.sv
module aavr_turn #(
    parameter int DATA_WIDTH = 18,
    parameter int COEF_WIDTH = 18
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    input  logic signed [DATA_WIDTH+aavr_pkg::HEADROOM-1:0] pz [3],
    input  logic signed [DATA_WIDTH+aavr_pkg::HEADROOM-1:0] px [3],
    input  logic signed [COEF_WIDTH-1:0]                axis [3],
    input  logic signed [COEF_WIDTH-1:0]                cos_angle,
    input  logic signed [COEF_WIDTH-1:0]                sin_angle,
    output logic                                        out_valid,
    output logic signed [DATA_WIDTH-1:0]                rot [3],
    output logic                                        clipped
);

    localparam int D   = DATA_WIDTH;
    localparam int C   = COEF_WIDTH;
    localparam int F   = C - aavr_pkg::FRAC_GAP;
    localparam int IW  = D + aavr_pkg::HEADROOM;
    localparam int MW  = C + IW - F;     // rounded coef * intermediate
    localparam int RW  = MW + 2;         // final three-term sum

    logic valid5_reg, valid6_reg, valid7_reg, valid8_reg;

    logic signed [IW-1:0] pz5_reg [3];
    logic signed [IW-1:0] pz6_reg [3];
    logic signed [IW-1:0] pz7_reg [3];
    logic signed [MW-1:0] cross_p [3];
    logic signed [MW-1:0] cross_n [3];
    logic signed [MW:0]   cross_d [3];
    logic signed [IW-1:0] py_next [3];
    logic signed [IW-1:0] py_reg  [3];
    logic signed [MW-1:0] cpx     [3];
    logic signed [MW-1:0] cpx6_reg [3];
    logic signed [MW-1:0] cpx7_reg [3];
    logic signed [MW-1:0] spy     [3];
    logic signed [RW-1:0] r_sum   [3];
    logic signed [D-1:0]  r_next  [3];
    logic signed [D-1:0]  rot_reg [3];
    logic [2:0]           r_sat;
    logic                 clipped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid5_reg <= 1'b0;
            valid6_reg <= 1'b0;
            valid7_reg <= 1'b0;
            valid8_reg <= 1'b0;
        end
        else
        begin
            valid5_reg <= in_valid;
            valid6_reg <= valid5_reg;
            valid7_reg <= valid6_reg;
            valid8_reg <= valid7_reg;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        // stage 5: cross(axis, px) terms and cos * px
        aavr_mulr #(.AW(C), .BW(IW), .FRAC(F)) u_mul_cp (
            .clk (clk),
            .a   (axis[J]),
            .b   (px[K]),
            .y   (cross_p[i])
        );

        aavr_mulr #(.AW(C), .BW(IW), .FRAC(F)) u_mul_cn (
            .clk (clk),
            .a   (axis[K]),
            .b   (px[J]),
            .y   (cross_n[i])
        );

        aavr_mulr #(.AW(C), .BW(IW), .FRAC(F)) u_mul_cos (
            .clk (clk),
            .a   (cos_angle),
            .b   (px[i]),
            .y   (cpx[i])
        );

        // stage 6: perpendicular turned by 90 degrees
        assign cross_d[i] = (MW+1)'(cross_p[i]) - (MW+1)'(cross_n[i]);

        aavr_sat #(.IW(MW+1), .OW(IW)) u_sat_py (
            .x   (cross_d[i]),
            .y   (py_next[i]),
            .sat ()
        );

        // stage 7: sin * py
        aavr_mulr #(.AW(C), .BW(IW), .FRAC(F)) u_mul_sin (
            .clk (clk),
            .a   (sin_angle),
            .b   (py_reg[i]),
            .y   (spy[i])
        );

        // stage 8: recombine and clip to the data width
        assign r_sum[i] = RW'(pz7_reg[i]) + RW'(cpx7_reg[i]) + RW'(spy[i]);

        aavr_sat #(.IW(RW), .OW(D)) u_sat_r (
            .x   (r_sum[i]),
            .y   (r_next[i]),
            .sat (r_sat[i])
        );

        always_ff @(posedge clk)
        begin
            pz5_reg[i]  <= pz[i];
            pz6_reg[i]  <= pz5_reg[i];
            pz7_reg[i]  <= pz6_reg[i];
            py_reg[i]   <= py_next[i];
            cpx6_reg[i] <= cpx[i];
            cpx7_reg[i] <= cpx6_reg[i];
            rot_reg[i]  <= r_next[i];
        end

        assign rot[i] = rot_reg[i];
    end

    always_ff @(posedge clk)
    begin
        clipped_reg <= |r_sat;
    end

    assign out_valid = valid8_reg;
    assign clipped   = clipped_reg;

endmodule

### hdl/axis_angle_vector_rotation_core.sv
// Axis-angle vector rotation core (Rodrigues rotation formula).
//
// Input: pulse start with vec_x/vec_y/vec_z; the transfer happens at any
// rising edge with start high and busy low. busy stays low, so one vector
// may be started in every cycle, back to back, with no gaps.
// Output: done is high for exactly one cycle with rot_x/rot_y/rot_z and
// clipped; the receiver must take the transfer in that cycle, it has no
// way to hold results off. Results leave in input order.
// Throughput: one vector per cycle; each of the eight stages takes a new
// vector in every cycle (multiply stages alternate with round/add/clip).
// Config: cfg_wr_en/cfg_index/cfg_data write axis_x, axis_y, axis_z,
// cos_angle, sin_angle (indexes 0..4, others ignored). Write only while no
// vector is in flight: the pipeline reads the live values.
// Reset: all in-flight vectors are dropped (done low); the axis becomes
// +y and the angle zero (cos 1.0, sin 0), so vectors pass through as is.
module axis_angle_vector_rotation_core #(
    parameter int DATA_WIDTH = 18,
    parameter int COEF_WIDTH = 18
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // command channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [DATA_WIDTH-1:0]          vec_x,
    input  logic signed [DATA_WIDTH-1:0]          vec_y,
    input  logic signed [DATA_WIDTH-1:0]          vec_z,
    // result channel
    output logic                                  done,
    output logic signed [DATA_WIDTH-1:0]          rot_x,
    output logic signed [DATA_WIDTH-1:0]          rot_y,
    output logic signed [DATA_WIDTH-1:0]          rot_z,
    output logic                                  clipped,
    // register write port
    input  logic                                  cfg_wr_en,
    input  logic [aavr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [COEF_WIDTH-1:0]                 cfg_data
);

    localparam int D  = DATA_WIDTH;
    localparam int C  = COEF_WIDTH;
    localparam int F  = C - aavr_pkg::FRAC_GAP;
    localparam int IW = D + aavr_pkg::HEADROOM;

    // 1.0 in Q1.F
    localparam logic signed [C-1:0] ONE = {2'b01, {F{1'b0}}};

    logic signed [C-1:0] axis_x_reg, axis_y_reg, axis_z_reg;
    logic signed [C-1:0] cos_angle_reg, sin_angle_reg;

    logic signed [C-1:0]  axis  [3];
    logic signed [D-1:0]  vec   [3];
    logic signed [IW-1:0] pz    [3];
    logic signed [IW-1:0] px    [3];
    logic signed [D-1:0]  rot   [3];
    logic                 in_valid;
    logic                 mid_valid;

    // register file: written when cfg_wr_en is high, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_x_reg    <= '0;
            axis_y_reg    <= ONE;
            axis_z_reg    <= '0;
            cos_angle_reg <= ONE;
            sin_angle_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                aavr_pkg::CFG_AXIS_X:    axis_x_reg    <= cfg_data;
                aavr_pkg::CFG_AXIS_Y:    axis_y_reg    <= cfg_data;
                aavr_pkg::CFG_AXIS_Z:    axis_z_reg    <= cfg_data;
                aavr_pkg::CFG_COS_ANGLE: cos_angle_reg <= cfg_data;
                aavr_pkg::CFG_SIN_ANGLE: sin_angle_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // fully pipelined, never refuses a start
    assign busy     = 1'b0;
    assign in_valid = start & ~busy;

    assign axis[0] = axis_x_reg;
    assign axis[1] = axis_y_reg;
    assign axis[2] = axis_z_reg;
    assign vec[0]  = vec_x;
    assign vec[1]  = vec_y;
    assign vec[2]  = vec_z;

    // stages 1-4: d = a.v, pz = a*d, px = v - pz
    aavr_proj #(.DATA_WIDTH(D), .COEF_WIDTH(C)) u_proj (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .vec       (vec),
        .axis      (axis),
        .out_valid (mid_valid),
        .pz        (pz),
        .px        (px)
    );

    // stages 5-8: py = a x px, r = pz + c*px + s*py
    aavr_turn #(.DATA_WIDTH(D), .COEF_WIDTH(C)) u_turn (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .pz        (pz),
        .px        (px),
        .axis      (axis),
        .cos_angle (cos_angle_reg),
        .sin_angle (sin_angle_reg),
        .out_valid (done),
        .rot       (rot),
        .clipped   (clipped)
    );

    assign rot_x = rot[0];
    assign rot_y = rot[1];
    assign rot_z = rot[2];

endmodule
